// ----- hw/rtl/bpit_pkg.sv -----
// Shared types for the barycentric point-in-triangle test.
package bpit_pkg;

  // Flags carried through the divider chain alongside the quotients.
  typedef struct packed {
    logic vld;
    logic in_tri;
    logic ccw;
    logic degenerate;
  } bpit_flags_t;

endpackage

// ----- hw/rtl/bpit_front.sv -----
// Front stages: edge differences, cross products, sign fold and inside test.
module bpit_front import bpit_pkg::*; #(
  parameter int COORD_WIDTH = 16,
  parameter int PW = 2 * COORD_WIDTH + 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [COORD_WIDTH-1:0] a_x,
  input  logic signed [COORD_WIDTH-1:0] a_y,
  input  logic signed [COORD_WIDTH-1:0] b_x,
  input  logic signed [COORD_WIDTH-1:0] b_y,
  input  logic signed [COORD_WIDTH-1:0] c_x,
  input  logic signed [COORD_WIDTH-1:0] c_y,
  input  logic signed [COORD_WIDTH-1:0] p_x,
  input  logic signed [COORD_WIDTH-1:0] p_y,
  output bpit_flags_t                   flags,
  output logic        [PW-1:0]          un_out,
  output logic        [PW-1:0]          vn_out,
  output logic        [PW-1:0]          den_out
);

  localparam int DW = COORD_WIDTH + 1;

  // stage 1: differences
  logic signed [DW-1:0] v0x, v0y, v1x, v1y, v2x, v2y;
  logic                 vld1;
  // stage 2: products
  logic signed [PW-1:0] p_den0, p_den1, p_un0, p_un1, p_vn0, p_vn1;
  logic                 vld2;
  // stage 3: cross products
  logic signed [PW-1:0] den3, un3, vn3;
  logic                 vld3;

  logic signed [PW-1:0] den_abs, un_f, vn_f;
  logic                 neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1  <= 1'b0;
      vld2  <= 1'b0;
      vld3  <= 1'b0;
      flags <= '0;
    end else begin
      vld1      <= start;
      vld2      <= vld1;
      vld3      <= vld2;
      flags.vld <= vld3;
      flags.degenerate <= (den3 == '0);
      flags.ccw        <= den3[PW-1];
      flags.in_tri     <= (den3 != '0) && !un_f[PW-1] && !vn_f[PW-1] &&
                          ((un_f + vn_f) <= den_abs);
    end
  end

  always_ff @(posedge clk) begin
    v0x <= DW'(c_x) - DW'(a_x);
    v0y <= DW'(c_y) - DW'(a_y);
    v1x <= DW'(b_x) - DW'(a_x);
    v1y <= DW'(b_y) - DW'(a_y);
    v2x <= DW'(p_x) - DW'(a_x);
    v2y <= DW'(p_y) - DW'(a_y);
    p_den0 <= PW'(v0x) * PW'(v1y);
    p_den1 <= PW'(v0y) * PW'(v1x);
    p_un0  <= PW'(v2x) * PW'(v1y);
    p_un1  <= PW'(v2y) * PW'(v1x);
    p_vn0  <= PW'(v0x) * PW'(v2y);
    p_vn1  <= PW'(v0y) * PW'(v2x);
    den3 <= p_den0 - p_den1;
    un3  <= p_un0 - p_un1;
    vn3  <= p_vn0 - p_vn1;
    den_out <= den_abs;
    un_out  <= un_f;
    vn_out  <= vn_f;
  end

  // fold sign so the denominator is positive
  always_comb begin
    neg     = den3[PW-1];
    den_abs = neg ? -den3 : den3;
    un_f    = neg ? -un3 : un3;
    vn_f    = neg ? -vn3 : vn3;
  end

endmodule

// ----- hw/rtl/bpit_div_cell.sv -----
// One restoring-division cell: one quotient bit for each of two dividends.
module bpit_div_cell import bpit_pkg::*; #(
  parameter int PW = 36,
  parameter int QW = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  bpit_flags_t       flags_in,
  input  logic [PW-1:0]     den_in,
  input  logic [PW-1:0]     ru_in,
  input  logic [PW-1:0]     rv_in,
  input  logic [QW-1:0]     qu_in,
  input  logic [QW-1:0]     qv_in,
  input  logic              shift_in,
  output bpit_flags_t       flags_out,
  output logic [PW-1:0]     den_out,
  output logic [PW-1:0]     ru_out,
  output logic [PW-1:0]     rv_out,
  output logic [QW-1:0]     qu_out,
  output logic [QW-1:0]     qv_out
);

  logic [PW:0] ru_s, rv_s;
  logic        bu, bv;

  // remainder stays below den, so one extra bit covers the shift
  always_comb begin
    ru_s = shift_in ? {ru_in, 1'b0} : {1'b0, ru_in};
    rv_s = shift_in ? {rv_in, 1'b0} : {1'b0, rv_in};
    bu   = (ru_s >= {1'b0, den_in});
    bv   = (rv_s >= {1'b0, den_in});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags_out <= '0;
    end else begin
      flags_out <= flags_in;
    end
  end

  always_ff @(posedge clk) begin
    den_out <= den_in;
    ru_out  <= PW'(bu ? ru_s - {1'b0, den_in} : ru_s);
    rv_out  <= PW'(bv ? rv_s - {1'b0, den_in} : rv_s);
    qu_out  <= {qu_in[QW-2:0], bu};
    qv_out  <= {qv_in[QW-2:0], bv};
  end

endmodule

// ----- hw/rtl/barycentric_point_in_triangle_top.sv -----
// Top level of the barycentric point-in-triangle test.
//
// One item is accepted in every clock cycle (busy is tied low), and its
// result appears with done high after it has passed the front stages for
// differences, products, cross products and sign fold, a chain of
// WEIGHT_FRAC + 1 division cells, one quotient bit each, and one output
// register. The receiver cannot stall: each result is shown for one cycle
// only and must be taken then. Weights are exact floors of u and v scaled
// by 2^WEIGHT_FRAC; weight_a makes the three sum to 2^WEIGHT_FRAC. Outside
// or degenerate triangles give zero weights.
module barycentric_point_in_triangle_top import bpit_pkg::*; #(
  parameter int COORD_WIDTH = 16,
  parameter int WEIGHT_FRAC = 15
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] a_x,
  input  logic signed [COORD_WIDTH-1:0] a_y,
  input  logic signed [COORD_WIDTH-1:0] b_x,
  input  logic signed [COORD_WIDTH-1:0] b_y,
  input  logic signed [COORD_WIDTH-1:0] c_x,
  input  logic signed [COORD_WIDTH-1:0] c_y,
  input  logic signed [COORD_WIDTH-1:0] p_x,
  input  logic signed [COORD_WIDTH-1:0] p_y,
  output logic                          done,
  output logic                          hit,
  output logic                          inside_res,
  output logic                          ccw,
  output logic                          degenerate,
  output logic [15:0]                   weight_a,
  output logic [15:0]                   weight_b,
  output logic [15:0]                   weight_c
);

  localparam int PW = 2 * COORD_WIDTH + 4;
  localparam int NC = WEIGHT_FRAC + 1;
  localparam int QW = WEIGHT_FRAC + 1;
  localparam int WW = WEIGHT_FRAC + 2;

  bpit_flags_t       fl  [NC+1];
  logic [PW-1:0]     den [NC+1];
  logic [PW-1:0]     ru  [NC+1];
  logic [PW-1:0]     rv  [NC+1];
  logic [QW-1:0]     qu  [NC+1];
  logic [QW-1:0]     qv  [NC+1];

  logic [WW-1:0] wb_full, wc_full, wa_full;

  // fully pipelined, never stalls the sender
  assign busy = 1'b0;

  bpit_front #(.COORD_WIDTH(COORD_WIDTH), .PW(PW)) u_front (
    .clk(clk), .rst(rst), .start(start),
    .a_x(a_x), .a_y(a_y), .b_x(b_x), .b_y(b_y),
    .c_x(c_x), .c_y(c_y), .p_x(p_x), .p_y(p_y),
    .flags(fl[0]), .un_out(ru[0]), .vn_out(rv[0]), .den_out(den[0])
  );

  assign qu[0] = '0;
  assign qv[0] = '0;

  // first cell takes the integer bit without shifting, the rest shift
  for (genvar i = 0; i < NC; i++) begin : g_cell
    bpit_div_cell #(.PW(PW), .QW(QW)) u_cell (
      .clk(clk), .rst(rst),
      .flags_in(fl[i]), .den_in(den[i]), .ru_in(ru[i]), .rv_in(rv[i]),
      .qu_in(qu[i]), .qv_in(qv[i]), .shift_in(i != 0),
      .flags_out(fl[i+1]), .den_out(den[i+1]), .ru_out(ru[i+1]),
      .rv_out(rv[i+1]), .qu_out(qu[i+1]), .qv_out(qv[i+1])
    );
  end

  always_comb begin
    wc_full = fl[NC].in_tri ? WW'(qu[NC]) : '0;
    wb_full = fl[NC].in_tri ? WW'(qv[NC]) : '0;
    wa_full = fl[NC].in_tri ? (WW'(1) << WEIGHT_FRAC) - wb_full - wc_full : '0;
  end

  // register the result; hold it for one cycle with done
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fl[NC].vld;
    end
  end

  always_ff @(posedge clk) begin
    inside_res <= fl[NC].in_tri;
    ccw        <= fl[NC].ccw;
    degenerate <= fl[NC].degenerate;
    hit        <= fl[NC].in_tri & fl[NC].ccw;
    weight_a   <= 16'(wa_full);
    weight_b   <= 16'(wb_full);
    weight_c   <= 16'(wc_full);
  end

endmodule
